/* hdl/ssp_pkg.sv */
// ssp_pkg: shared types, constants and gap-table functions for the Pratt shellsort unit.
// No dependencies; used by ssp_tally and shell_insertion_sort_pratt_unit.
`default_nettype none

package ssp_pkg;

    localparam int VALUE_W   = 32;
    localparam int TALLY_W   = 16;
    localparam int GAP_W     = 5;   // largest gap is 27
    localparam int GAP_IDX_W = 4;   // ten table entries
    localparam int CNT_MAX_W = 7;   // counts up to 64

    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

    typedef logic [VALUE_W-1:0] t_value;

    typedef struct packed {
        logic clr;   // return both tallies to zero
        logic mv;    // one move
        logic cmp;   // two comparisons
    } t_tally_ctl;

    // Pratt 3-smooth gaps, diagonal by diagonal: 1 | 2 3 | 4 6 9 | 8 12 18 27
    function automatic logic [GAP_W-1:0] gap_at(input logic [GAP_IDX_W-1:0] idx);
        logic [GAP_W-1:0] g;
        case (idx)
            4'd0:    g = 5'd1;
            4'd1:    g = 5'd2;
            4'd2:    g = 5'd3;
            4'd3:    g = 5'd4;
            4'd4:    g = 5'd6;
            4'd5:    g = 5'd9;
            4'd6:    g = 5'd8;
            4'd7:    g = 5'd12;
            4'd8:    g = 5'd18;
            4'd9:    g = 5'd27;
            default: g = 5'd1;
        endcase
        return g;
    endfunction

    // Index of the last table entry for a set of cnt elements (n diagonals, 3^n >= cnt).
    // Sets of one element start at gap 1, which the sequencer skips since 1 >= cnt.
    function automatic logic [GAP_IDX_W-1:0] gap_top(input logic [CNT_MAX_W-1:0] cnt);
        logic [GAP_IDX_W-1:0] t;
        if (cnt <= 7'd3) begin
            t = 4'd0;
        end else if (cnt <= 7'd9) begin
            t = 4'd2;
        end else if (cnt <= 7'd27) begin
            t = 4'd5;
        end else begin
            t = 4'd9;
        end
        return t;
    endfunction

endpackage

`default_nettype wire

/* hdl/shell_insertion_sort_pratt_unit.sv */
// Loading: one element per cycle; the transaction with i_last set starts the sort.
// Sort: S_GAP steps through the gap table; each insertion runs S_FETCH, S_HOLD, then S_SCAN while
// elements shift, and S_SCAN or S_DROP to place the held one; bounded by the single RAM read port.
// Output: RAM read, then output register; the next element is read only once the last is accepted.
// Synchronous active-low reset clears count, tallies and sequencer; the element RAM is not
// cleared and needs no clearing pass. Input is stalled from the last element until the set drains.
`default_nettype none

module shell_insertion_sort_pratt_unit
    import ssp_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic               i_last,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic      [VALUE_W-1:0] o_sorted_value,
    output logic                    o_last_out,
    output logic      [TALLY_W-1:0] o_comparisons,
    output logic      [TALLY_W-1:0] o_moves
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CW     = (CNT_W > GAP_W) ? CNT_W : GAP_W;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_GAP   = 4'd1;
    localparam logic [3:0] S_FETCH = 4'd2;
    localparam logic [3:0] S_HOLD  = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_DROP  = 4'd5;
    localparam logic [3:0] S_ERD   = 4'd6;
    localparam logic [3:0] S_EWAIT = 4'd7;
    localparam logic [3:0] S_EOUT  = 4'd8;

    logic [3:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [GAP_IDX_W-1:0] r_t, n_t;
    logic [ADDR_W-1:0]    r_gap, n_gap;
    logic [ADDR_W-1:0]    r_j, n_j;
    logic [ADDR_W-1:0]    r_k, n_k;
    logic [ADDR_W-1:0]    r_i, n_i;
    t_value               r_held, n_held;
    t_value               r_out_value, n_out_value;
    logic                 r_out_last, n_out_last;

    logic                 ram_we, ram_re;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
    t_value               ram_wdata, ram_rdata;
    t_tally_ctl           tally_ctl;

    logic                 in_acc, out_acc;
    logic [GAP_W-1:0]     gap_val;
    logic [ADDR_W-1:0]    k_step;
    logic                 more_j;
    logic                 shift;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign gap_val = gap_at(r_t);
    assign k_step  = r_k - r_gap;
    assign more_j  = (CNT_W'(r_j) + CNT_W'(1)) < r_count;
    assign shift   = $signed(ram_rdata) > $signed(r_held);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_t         = r_t;
        n_gap       = r_gap;
        n_j         = r_j;
        n_k         = r_k;
        n_i         = r_i;
        n_held      = r_held;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        ram_we      = 1'b0;
        ram_waddr   = r_k;
        ram_wdata   = r_held;
        ram_re      = 1'b0;
        ram_raddr   = r_j;
        tally_ctl   = '0;

        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (r_count < CNT_W'(DEPTH)) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_count[ADDR_W-1:0];
                        ram_wdata = i_value;
                        n_count   = r_count + CNT_W'(1);
                    end
                    if (i_last) begin
                        n_t     = gap_top(CNT_MAX_W'(n_count));
                        n_state = S_GAP;
                    end
                end
            end
            S_GAP: begin
                if (CW'(gap_val) < CW'(r_count)) begin
                    n_gap   = ADDR_W'(gap_val);
                    n_j     = ADDR_W'(gap_val);
                    n_state = S_FETCH;
                end else if (r_t == '0) begin
                    n_state = S_ERD;
                end else begin
                    n_t = r_t - GAP_IDX_W'(1);
                end
            end
            S_FETCH: begin
                ram_re    = 1'b1;
                ram_raddr = r_j;
                n_state   = S_HOLD;
            end
            S_HOLD: begin
                // lift element j; j >= gap so the first neighbor always exists
                n_held       = ram_rdata;
                n_k          = r_j;
                tally_ctl.mv = 1'b1;
                ram_re       = 1'b1;
                ram_raddr    = r_j - r_gap;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                tally_ctl.mv  = 1'b1;
                tally_ctl.cmp = 1'b1;
                ram_we        = 1'b1;
                ram_waddr     = r_k;
                if (shift) begin
                    ram_wdata = ram_rdata;
                    n_k       = k_step;
                    if (k_step >= r_gap) begin
                        ram_re    = 1'b1;
                        ram_raddr = k_step - r_gap;
                    end else begin
                        n_state = S_DROP;
                    end
                end else begin
                    ram_wdata = r_held;
                    if (more_j) begin
                        n_j     = r_j + ADDR_W'(1);
                        n_state = S_FETCH;
                    end else if (r_t == '0) begin
                        n_state = S_ERD;
                    end else begin
                        n_t     = r_t - GAP_IDX_W'(1);
                        n_state = S_GAP;
                    end
                end
            end
            S_DROP: begin
                tally_ctl.mv  = 1'b1;
                tally_ctl.cmp = 1'b1;
                ram_we        = 1'b1;
                ram_waddr     = r_k;
                ram_wdata     = r_held;
                if (more_j) begin
                    n_j     = r_j + ADDR_W'(1);
                    n_state = S_FETCH;
                end else if (r_t == '0) begin
                    n_state = S_ERD;
                end else begin
                    n_t     = r_t - GAP_IDX_W'(1);
                    n_state = S_GAP;
                end
            end
            S_ERD: begin
                n_i       = '0;
                ram_re    = 1'b1;
                ram_raddr = '0;
                n_state   = S_EWAIT;
            end
            S_EWAIT: begin
                n_out_value = ram_rdata;
                n_out_last  = (CNT_W'(r_i) + CNT_W'(1)) == r_count;
                n_state     = S_EOUT;
            end
            S_EOUT: begin
                if (out_acc) begin
                    if (r_out_last) begin
                        n_count       = '0;
                        tally_ctl.clr = 1'b1;
                        n_state       = S_LOAD;
                    end else begin
                        n_i       = r_i + ADDR_W'(1);
                        ram_re    = 1'b1;
                        ram_raddr = r_i + ADDR_W'(1);
                        n_state   = S_EWAIT;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t         <= n_t;
        r_gap       <= n_gap;
        r_j         <= n_j;
        r_k         <= n_k;
        r_i         <= n_i;
        r_held      <= n_held;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    ssp_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ssp_tally u_tally (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (tally_ctl),
        .o_comparisons (o_comparisons),
        .o_moves       (o_moves)
    );

    assign o_stall        = (r_state != S_LOAD);
    assign o_valid        = (r_state == S_EOUT);
    assign o_sorted_value = r_out_value;
    assign o_last_out     = r_out_last;

    // same-cycle read and write never hit one entry
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("RAM read and write to the same entry");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count beyond depth");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_k >= r_gap && r_k <= r_j))
        else $error("scan index out of range");

    a_drain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last_out) |=> (r_state == S_LOAD && r_count == '0
                                     && o_comparisons == '0 && o_moves == '0))
        else $error("state not cleared after final transaction");

    a_tally_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EOUT && $past(r_state) == S_EOUT) |-> ($stable(o_comparisons)
                                                           && $stable(o_moves)))
        else $error("tallies changed during output");

endmodule

`default_nettype wire

/* hdl/ssp_ram.sv */
// ssp_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module ssp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/ssp_tally.sv */
// ssp_tally: saturating comparison and move counters.
// Depends on ssp_pkg.
`default_nettype none

module ssp_tally
    import ssp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_tally_ctl         i_ctl,
    output logic      [TALLY_W-1:0] o_comparisons,
    output logic      [TALLY_W-1:0] o_moves
);

    logic [TALLY_W-1:0] r_cmp, n_cmp;
    logic [TALLY_W-1:0] r_mv, n_mv;
    logic [TALLY_W:0]   cmp_sum, mv_sum;

    always_comb begin
        cmp_sum = {1'b0, r_cmp} + (TALLY_W+1)'(2);
        mv_sum  = {1'b0, r_mv} + (TALLY_W+1)'(1);
        n_cmp   = r_cmp;
        n_mv    = r_mv;
        if (i_ctl.clr) begin
            n_cmp = '0;
            n_mv  = '0;
        end else begin
            if (i_ctl.cmp) begin
                n_cmp = cmp_sum[TALLY_W] ? TALLY_MAX : cmp_sum[TALLY_W-1:0];
            end
            if (i_ctl.mv) begin
                n_mv = mv_sum[TALLY_W] ? TALLY_MAX : mv_sum[TALLY_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp <= '0;
            r_mv  <= '0;
        end else begin
            r_cmp <= n_cmp;
            r_mv  <= n_mv;
        end
    end

    assign o_comparisons = r_cmp;
    assign o_moves       = r_mv;

endmodule

`default_nettype wire
